// ----- rtl/bvil_pkg.sv -----
// Package for the beacon vendor information-element locator.
// Result type, register indexes and reset values; no dependencies.
`timescale 1ns / 1ps

package bvil_pkg;

    typedef enum logic [1:0] {
        REG_FRAME_TYPE = 2'd0,
        REG_ELEM_START = 2'd1,
        REG_WANTED_TAG = 2'd2,
        REG_UNUSED     = 2'd3
    } t_reg_index;

    localparam logic [7:0]  FRAME_TYPE_RESET = 8'h80;
    localparam logic [11:0] ELEM_START_RESET = 12'h024;
    localparam logic [7:0]  WANTED_TAG_RESET = 8'hDD;
    localparam logic [11:0] OFFSET_MAX       = 12'hFFF;

    typedef struct packed {
        logic        found;
        logic [11:0] ie_offset;
        logic [7:0]  ie_length;
        logic        too_long;
    } t_result;

endpackage

// ----- rtl/bvil_frame_walker.sv -----
// Per-frame walker: tracks byte position and the tag-length-value element chain.
// Emits one result item on the last byte of a frame. Depends on bvil_pkg.
`timescale 1ns / 1ps

module bvil_frame_walker #(
    parameter int MAX_FRAME = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_frame_byte,
    input  logic             i_last_byte,
    input  logic [7:0]       i_frame_type,
    input  logic [11:0]      i_elem_start,
    input  logic [7:0]       i_wanted_tag,
    output logic             o_result_valid,
    output bvil_pkg::t_result o_result
);
    import bvil_pkg::*;

    localparam int POS_W = $clog2(MAX_FRAME + 1);
    localparam int NT_W  = $clog2(MAX_FRAME + 4096);

    logic [POS_W-1:0] r_pos, n_pos;
    logic [NT_W-1:0]  r_next_tag, n_next_tag;
    logic             r_await, n_await;
    logic             r_is_beacon, n_is_beacon;
    logic             r_hit, n_hit;
    logic [11:0]      r_hit_offset, n_hit_offset;
    logic [7:0]       r_hit_length, n_hit_length;
    logic             r_overlong, n_overlong;

    logic [NT_W-1:0]  pos_ext;
    logic [NT_W-1:0]  off_sum;

    assign pos_ext = NT_W'(r_pos);
    assign off_sum = pos_ext + NT_W'(2);

    always_comb begin
        n_pos        = r_pos;
        n_next_tag   = r_next_tag;
        n_await      = r_await;
        n_is_beacon  = r_is_beacon;
        n_hit        = r_hit;
        n_hit_offset = r_hit_offset;
        n_hit_length = r_hit_length;
        n_overlong   = r_overlong;
        if (r_pos >= POS_W'(MAX_FRAME)) begin
            n_overlong = 1'b1;
        end else begin
            if (r_pos == '0) begin
                n_is_beacon = (i_frame_byte == i_frame_type);
                n_next_tag  = NT_W'(i_elem_start);
            end
            if (n_is_beacon) begin
                if (r_await) begin
                    n_await = 1'b0;
                    if (r_hit) begin
                        n_hit_length = i_frame_byte;
                    end else begin
                        n_next_tag = pos_ext + NT_W'(i_frame_byte) + NT_W'(1);
                    end
                end else if (!r_hit && pos_ext == n_next_tag) begin
                    n_await = 1'b1;
                    if (i_frame_byte == i_wanted_tag) begin
                        n_hit        = 1'b1;
                        n_hit_offset = (off_sum > NT_W'(OFFSET_MAX)) ? OFFSET_MAX
                                                                     : off_sum[11:0];
                        n_hit_length = 8'd0;
                    end
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    always_comb begin
        o_result.found     = n_hit;
        o_result.ie_offset = n_hit ? n_hit_offset : 12'd0;
        o_result.ie_length = n_hit ? n_hit_length : 8'd0;
        o_result.too_long  = n_overlong;
        o_result_valid     = i_accept && i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_pos        <= '0;
            r_next_tag   <= '0;
            r_await      <= 1'b0;
            r_is_beacon  <= 1'b0;
            r_hit        <= 1'b0;
            r_hit_offset <= 12'd0;
            r_hit_length <= 8'd0;
            r_overlong   <= 1'b0;
        end else if (i_accept) begin
            r_pos        <= n_pos;
            r_next_tag   <= n_next_tag;
            r_await      <= n_await;
            r_is_beacon  <= n_is_beacon;
            r_hit        <= n_hit;
            r_hit_offset <= n_hit_offset;
            r_hit_length <= n_hit_length;
            r_overlong   <= n_overlong;
        end
    end

endmodule

// ----- rtl/beacon_vendor_ie_locator.sv -----
// Top level of the beacon vendor information-element locator.
// Holds the APB register file and the output skid stage; uses bvil_pkg, bvil_frame_walker.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one frame byte per item,
//   with i_last_byte high on the final byte; one byte per cycle unless stalled.
//   Output channel (o_out_valid / i_out_stall) carries one result item per
//   frame: found, data offset, element length and the too-long flag.
//   The result of the last accepted byte is registered into the output register,
//   or into the skid register while the receiver stalls. Throughput: one byte
//   per cycle while o_in_stall is low, one walker step per accepted byte.
//   A result and one more behind it in the skid register can wait while the
//   receiver stalls; o_in_stall rises only when the skid register is full.
//   Frames longer than MAX_FRAME bytes set too_long; later bytes are dropped
//   except for their last-byte flag.
//   Registers: 0x0 frame type byte, 0x4 elements start, 0x8 wanted tag.
//   Synchronous reset clears frame state and the output stage and restores
//   register defaults (0x80, 36, 0xDD).
`timescale 1ns / 1ps

module beacon_vendor_ie_locator #(
    parameter int MAX_FRAME = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [11:0] o_ie_offset,
    output logic [7:0]  o_ie_length,
    output logic        o_too_long,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bvil_pkg::*;

    logic [7:0]  r_frame_type;
    logic [11:0] r_elem_start;
    logic [7:0]  r_wanted_tag;
    t_reg_index  reg_sel;
    logic        cfg_write;

    logic        in_accept;
    logic        res_valid;
    t_result     res;

    logic        r_out_valid;
    t_result     r_out;
    logic        r_skid_valid;
    t_result     r_skid;
    logic        out_free;

    assign pready    = 1'b1;
    assign reg_sel   = t_reg_index'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_type <= FRAME_TYPE_RESET;
            r_elem_start <= ELEM_START_RESET;
            r_wanted_tag <= WANTED_TAG_RESET;
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_FRAME_TYPE: r_frame_type <= pwdata[7:0];
                REG_ELEM_START: r_elem_start <= pwdata[11:0];
                REG_WANTED_TAG: r_wanted_tag <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_FRAME_TYPE: prdata = {24'd0, r_frame_type};
            REG_ELEM_START: prdata = {20'd0, r_elem_start};
            REG_WANTED_TAG: prdata = {24'd0, r_wanted_tag};
            default:        prdata = 32'd0;
        endcase
    end

    assign o_in_stall = r_skid_valid;
    assign in_accept  = i_in_valid && !o_in_stall;

    bvil_frame_walker #(
        .MAX_FRAME(MAX_FRAME)
    ) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_frame_byte   (i_frame_byte),
        .i_last_byte    (i_last_byte),
        .i_frame_type   (r_frame_type),
        .i_elem_start   (r_elem_start),
        .i_wanted_tag   (r_wanted_tag),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_out.found;
    assign o_ie_offset = r_out.ie_offset;
    assign o_ie_length = r_out.ie_length;
    assign o_too_long  = r_out.too_long;

endmodule
